FILE: hdl/frt_pkg.sv
// ============================================================================
// frt_pkg
// Shared constants, types and the arctangent table for the frame rotate and
// translate unit.
// ============================================================================
package frt_pkg;

	// Number of CORDIC iterations; anything above 32 behaves as 32.
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

	// Angles in Q.30 radians.
	localparam int ANG_W = 35;
	localparam int Z_W = 33;
	localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 35'sd6746518852;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;

	// CORDIC datapath in Q2.30.
	localparam int CW = 33;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30 = 33'sd1073741824;

	// Side data that travels with each point through the pipeline.
	typedef struct packed {
		logic action;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic flip;
	} frt_side_t;

	// Action codes.
	localparam logic ACT_LOCAL_TO_GLOBAL = 1'b0;
	localparam logic ACT_GLOBAL_TO_LOCAL = 1'b1;

	// atan(2^-i) * 2^30, truncated.
	function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
		logic signed [31:0] r;
		unique case (idx)
			5'd0: r = 32'sd843314856;
			5'd1: r = 32'sd497837829;
			5'd2: r = 32'sd263043836;
			5'd3: r = 32'sd133525158;
			5'd4: r = 32'sd67021686;
			5'd5: r = 32'sd33543515;
			5'd6: r = 32'sd16775850;
			5'd7: r = 32'sd8388437;
			5'd8: r = 32'sd4194282;
			5'd9: r = 32'sd2097149;
			5'd10: r = 32'sd1048575;
			5'd11: r = 32'sd524287;
			5'd12: r = 32'sd262143;
			5'd13: r = 32'sd131071;
			5'd14: r = 32'sd65535;
			5'd15: r = 32'sd32767;
			5'd16: r = 32'sd16383;
			5'd17: r = 32'sd8191;
			5'd18: r = 32'sd4095;
			5'd19: r = 32'sd2047;
			5'd20: r = 32'sd1023;
			5'd21: r = 32'sd511;
			5'd22: r = 32'sd255;
			5'd23: r = 32'sd127;
			5'd24: r = 32'sd63;
			5'd25: r = 32'sd31;
			5'd26: r = 32'sd15;
			5'd27: r = 32'sd7;
			5'd28: r = 32'sd3;
			5'd29: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/frt_pose_if.sv
// ============================================================================
// frt_pose_if
// Input channel: one point with the robot pose and the transform direction.
// ============================================================================
interface frt_pose_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [15:0] heading;

	modport source (output valid, action, point_x, point_y, robot_x, robot_y, heading,
		input ready);
	modport sink (input valid, action, point_x, point_y, robot_x, robot_y, heading,
		output ready);
endinterface

FILE: hdl/frt_result_if.sv
// ============================================================================
// frt_result_if
// Output channel: one transformed point with its saturation flag.
// ============================================================================
interface frt_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic saturated;

	modport source (output valid, out_x, out_y, saturated, input ready);
	modport sink (input valid, out_x, out_y, saturated, output ready);
endinterface

FILE: hdl/frt_reduce.sv
// ============================================================================
// frt_reduce
// First pipeline stage: heading range reduction and point offset.
// ============================================================================
module frt_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid,
	input  logic                          action,
	input  logic signed [31:0]            point_x,
	input  logic signed [31:0]            point_y,
	input  logic signed [31:0]            robot_x,
	input  logic signed [31:0]            robot_y,
	input  logic signed [15:0]            heading,
	output logic                          valid_s1,
	output logic signed [frt_pkg::Z_W-1:0] z_s1,
	output frt_pkg::frt_side_t            side_s1
);
	import frt_pkg::*;

	logic signed [ANG_W-1:0] z0, z1, z2;
	logic flip;
	logic signed [32:0] px, py, dx, dy;

	always_comb begin
		z0 = signed'({heading[15], heading, 18'b0});
		if (z0 > ANG_PI) begin
			z1 = z0 - ANG_TWO_PI;
		end else if (z0 < -ANG_PI) begin
			z1 = z0 + ANG_TWO_PI;
		end else begin
			z1 = z0;
		end
		// Fold into the right half plane; sine and cosine change sign.
		if (z1 > ANG_HALF_PI) begin
			z2 = z1 - ANG_PI;
			flip = 1'b1;
		end else if (z1 < -ANG_HALF_PI) begin
			z2 = z1 + ANG_PI;
			flip = 1'b1;
		end else begin
			z2 = z1;
			flip = 1'b0;
		end
		px = 33'(point_x);
		py = 33'(point_y);
		dx = px - 33'(robot_x);
		dy = py - 33'(robot_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s1 <= z2[Z_W-1:0];
			side_s1.action <= action;
			side_s1.a <= (action == ACT_GLOBAL_TO_LOCAL) ? dx : px;
			side_s1.b <= (action == ACT_GLOBAL_TO_LOCAL) ? dy : py;
			side_s1.rx <= robot_x;
			side_s1.ry <= robot_y;
			side_s1.flip <= flip;
		end
	end

endmodule

FILE: hdl/frt_cordic.sv
// ============================================================================
// frt_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration, followed
// by a stage that clamps and applies the half-plane sign flip.
// ============================================================================
module frt_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           valid_in,
	input  logic signed [frt_pkg::Z_W-1:0] z_in,
	input  frt_pkg::frt_side_t             side_in,
	output logic                           valid_sf,
	output logic signed [31:0]             cos_sf,
	output logic signed [31:0]             sin_sf,
	output frt_pkg::frt_side_t             side_sf
);
	import frt_pkg::*;

	logic                  v_s    [CORDIC_N];
	logic signed [CW-1:0]  x_s    [CORDIC_N];
	logic signed [CW-1:0]  y_s    [CORDIC_N];
	logic signed [Z_W-1:0] z_s    [CORDIC_N];
	frt_side_t             side_s [CORDIC_N];

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
		logic                  vi;
		logic signed [CW-1:0]  xi, yi, xn, yn;
		logic signed [Z_W-1:0] zi, zn, at;
		frt_side_t             si;

		if (i == 0) begin : g_first
			assign vi = valid_in;
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
			assign si = side_in;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign si = side_s[i-1];
		end

		assign at = Z_W'(atan_q30(5'(i)));

		always_comb begin
			if (zi >= 0) begin
				xn = xi - (yi >>> i);
				yn = yi + (xi >>> i);
				zn = zi - at;
			end else begin
				xn = xi + (yi >>> i);
				yn = yi - (xi >>> i);
				zn = zi + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[i] <= xn;
				y_s[i] <= yn;
				z_s[i] <= zn;
				side_s[i] <= si;
			end
		end
	end

	logic signed [CW-1:0] xc, yc, xf, yf;

	always_comb begin
		xc = x_s[CORDIC_N-1];
		yc = y_s[CORDIC_N-1];
		if (xc > ONE_Q30) xc = ONE_Q30;
		else if (xc < -ONE_Q30) xc = -ONE_Q30;
		if (yc > ONE_Q30) yc = ONE_Q30;
		else if (yc < -ONE_Q30) yc = -ONE_Q30;
		xf = side_s[CORDIC_N-1].flip ? -xc : xc;
		yf = side_s[CORDIC_N-1].flip ? -yc : yc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else if (adv) begin
			valid_sf <= v_s[CORDIC_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_sf <= xf[31:0];
			sin_sf <= yf[31:0];
			side_sf <= side_s[CORDIC_N-1];
		end
	end

endmodule

FILE: hdl/frt_combine.sv
// ============================================================================
// frt_combine
// Multiply, sum and round/saturate stages; the last stage is the output
// register of the block.
// ============================================================================
module frt_combine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_in,
	input  logic signed [31:0] cos_in,
	input  logic signed [31:0] sin_in,
	input  frt_pkg::frt_side_t side_in,
	output logic               valid_q,
	output logic signed [31:0] out_x_q,
	output logic signed [31:0] out_y_q,
	output logic               sat_q
);
	import frt_pkg::*;

	localparam int PW = 65;
	localparam int SW = 66;
	localparam logic signed [SW-1:0] HALF_LSB = 66'sd536870912;

	// Multiply stage.
	logic                 valid_s1;
	logic                 action_s1;
	logic signed [31:0]   rx_s1, ry_s1;
	logic signed [PW-1:0] ac_s1, bs_s1, as_s1, bc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= side_in.action;
			rx_s1 <= side_in.rx;
			ry_s1 <= side_in.ry;
			ac_s1 <= PW'(side_in.a) * PW'(cos_in);
			bs_s1 <= PW'(side_in.b) * PW'(sin_in);
			as_s1 <= PW'(side_in.a) * PW'(sin_in);
			bc_s1 <= PW'(side_in.b) * PW'(cos_in);
		end
	end

	// Sum stage.
	logic                 valid_s2;
	logic signed [SW-1:0] vx_s2, vy_s2;
	logic signed [SW-1:0] rxa, rya, vx, vy;

	always_comb begin
		rxa = signed'({{4{rx_s1[31]}}, rx_s1, 30'b0});
		rya = signed'({{4{ry_s1[31]}}, ry_s1, 30'b0});
		if (action_s1 == ACT_LOCAL_TO_GLOBAL) begin
			vx = SW'(ac_s1) - SW'(bs_s1) + rxa;
			vy = SW'(as_s1) + SW'(bc_s1) + rya;
		end else begin
			vx = SW'(ac_s1) + SW'(bs_s1);
			vy = SW'(bc_s1) - SW'(as_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s2 <= vx;
			vy_s2 <= vy;
		end
	end

	// Round to nearest and saturate to 32 bits.
	logic signed [SW-1:0] rx_sum, ry_sum;
	logic [35:0] qx, qy;
	logic ovx, ovy;
	logic signed [31:0] fx, fy;

	always_comb begin
		rx_sum = vx_s2 + HALF_LSB;
		ry_sum = vy_s2 + HALF_LSB;
		qx = rx_sum[65:30];
		qy = ry_sum[65:30];
		ovx = !((&qx[35:31]) || !(|qx[35:31]));
		ovy = !((&qy[35:31]) || !(|qy[35:31]));
		if (ovx) fx = qx[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else fx = signed'(qx[31:0]);
		if (ovy) fy = qy[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else fy = signed'(qy[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q <= fx;
			out_y_q <= fy;
			sat_q <= ovx | ovy;
		end
	end

endmodule

FILE: hdl/frame_rotate_translate_unit.sv
// ============================================================================
// frame_rotate_translate_unit
// Planar rigid transform of a point between the robot frame and the global
// frame, with CORDIC sine and cosine of the robot heading.
// ============================================================================
// Usage:
// A point, the robot position, the heading (signed Q3.12 radians) and the
// action arrive on the pose channel. Action local to global rotates the point
// by the heading and adds the robot position; action global to local
// subtracts the position and rotates by minus the heading. Each transfer in
// produces exactly one transfer out on the result channel carrying out_x,
// out_y (signed Q16.16, rounded to nearest) and a saturated flag that is set
// when either coordinate was clipped to the 32-bit range.
// Throughput is one point per clock while the output is not stalled. The
// pipeline has one stage for heading range reduction, one per CORDIC
// iteration, one for clamp and sign fold, one for the four multiplies, one
// for the sums and one for rounding into the output register. The whole
// pipeline advances together whenever the output register is empty or being
// drained. When the receiver stalls on a full output, ready drops in the
// same cycle and every stage holds its item, so nothing is lost or repeated.
// Reset clears all valid bits; the block carries no state between points.
// ============================================================================
module frame_rotate_translate_unit (
	input logic          clk,
	input logic          arst_n,
	frt_pose_if.sink     pose,
	frt_result_if.source result
);
	import frt_pkg::*;

	// Global advance: the output register can take a new item.
	logic adv;
	logic out_valid;

	assign adv = !out_valid || result.ready;
	assign pose.ready = adv;

	// Stage 1: range reduction of the heading and the point offset.
	logic                  red_valid;
	logic signed [Z_W-1:0] red_z;
	frt_side_t             red_side;

	frt_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid    (pose.valid),
		.action   (pose.action),
		.point_x  (pose.point_x),
		.point_y  (pose.point_y),
		.robot_x  (pose.robot_x),
		.robot_y  (pose.robot_y),
		.heading  (pose.heading),
		.valid_s1 (red_valid),
		.z_s1     (red_z),
		.side_s1  (red_side)
	);

	// CORDIC iterations and the final clamp with sign fold.
	logic               cor_valid;
	logic signed [31:0] cor_cos, cor_sin;
	frt_side_t          cor_side;

	frt_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (red_valid),
		.z_in     (red_z),
		.side_in  (red_side),
		.valid_sf (cor_valid),
		.cos_sf   (cor_cos),
		.sin_sf   (cor_sin),
		.side_sf  (cor_side)
	);

	// Products, sums, rounding and saturation into the output register.
	frt_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (cor_valid),
		.cos_in   (cor_cos),
		.sin_in   (cor_sin),
		.side_in  (cor_side),
		.valid_q  (out_valid),
		.out_x_q  (result.out_x),
		.out_y_q  (result.out_y),
		.sat_q    (result.saturated)
	);

	assign result.valid = out_valid;

endmodule

FILE: sim/tb.sv
// ============================================================================
// tb
// Self-checking bench for frame_rotate_translate_unit. A directed table of
// poses (zero points, range corners, heading fold and wrap boundaries) is
// followed by about 1600 random poses. Every transfer into the block without
// a hand-written answer is predicted by a bit-exact CORDIC and fixed-point
// model of the transform, and every result transfer is compared field by
// field in arrival order. Both channels idle at random, and the result side
// twice holds off long enough to fill the pipeline and stall the pose channel.
// ============================================================================
module tb;
	import frt_pkg::*;

	// One pose as it is driven onto the pose channel.
	typedef struct packed {
		logic action;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [15:0] heading;
	} pose_t;

	// One transformed point as it leaves the block.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic sat;
	} xform_t;

	// A row of the directed table. When typed is set, want holds the answer
	// written out by hand; otherwise the predictor supplies it.
	typedef struct packed {
		pose_t pose;
		logic typed;
		xform_t want;
	} stim_row_t;

	localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [15:0] H_MAX = 16'sh7FFF;
	localparam logic signed [15:0] H_MIN = 16'sh8000;
	localparam xform_t NO_ANSWER = '0;

	// Angle constants in Q.30 radians and the Q2.30 datapath constants.
	localparam longint ANGLE_PI = 64'sd3373259426;
	localparam longint ANGLE_2PI = 64'sd6746518852;
	localparam longint ANGLE_HALF_PI = 64'sd1686629713;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	// atan(2^-k) in Q.30, truncated.
	localparam longint ARCTAN_Q30 [32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7, 3, 1, 0, 0
	};

	// Headings where the range reduction changes course, in Q3.12.
	localparam logic signed [15:0] HEADING_EDGES [9] = '{
		16'sd0, 16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868,
		16'sd25736, -16'sd25736, H_MAX, H_MIN
	};

	localparam int RANDOM_POSES = 1600;
	localparam int DIRECTED_ROWS = 22;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// A zero point at the origin stays at the origin.
		'{'{ACT_LOCAL_TO_GLOBAL, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0},
			1'b1, '{32'sd0, 32'sd0, 1'b0}},
		// A zero point lands exactly on the robot, whatever the heading.
		'{'{ACT_LOCAL_TO_GLOBAL, 32'sd0, 32'sd0, P_MAX, P_MIN, 16'sd12345},
			1'b1, '{P_MAX, P_MIN, 1'b0}},
		'{'{ACT_LOCAL_TO_GLOBAL, 32'sd0, 32'sd0, P_MIN, P_MAX, H_MIN},
			1'b1, '{P_MIN, P_MAX, 1'b0}},
		// A point on the robot is the local origin.
		'{'{ACT_GLOBAL_TO_LOCAL, P_MAX, P_MIN, P_MAX, P_MIN, H_MAX},
			1'b1, '{32'sd0, 32'sd0, 1'b0}},
		// The widest differences clip in both coordinates.
		'{'{ACT_GLOBAL_TO_LOCAL, P_MAX, P_MAX, P_MIN, P_MIN, 16'sd0},
			1'b1, '{P_MAX, P_MAX, 1'b1}},
		'{'{ACT_GLOBAL_TO_LOCAL, P_MIN, P_MIN, P_MAX, P_MAX, 16'sd0},
			1'b1, '{P_MIN, P_MIN, 1'b1}},
		// Unit vector across the quarter-turn fold.
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, 32'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, 32'sd0, 32'sd0, 32'sd0, 16'sd6433}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, 32'sd0, 32'sd0, 32'sd0, 16'sd6434}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, 32'sd0, 32'sd0, 32'sd0, -16'sd6433}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, 32'sd0, 32'sd0, 32'sd0, -16'sd6434}, 1'b0, NO_ANSWER},
		// Across the half-turn wrap.
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, ONE, 32'sd0, 32'sd0, 16'sd12867}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, ONE, 32'sd0, 32'sd0, 16'sd12868}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, ONE, 32'sd0, 32'sd0, -16'sd12867}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, ONE, ONE, 32'sd0, 32'sd0, -16'sd12868}, 1'b0, NO_ANSWER},
		// Heading extremes, one full turn and more.
		'{'{ACT_GLOBAL_TO_LOCAL, 3 * ONE, -ONE, ONE, ONE, H_MAX}, 1'b0, NO_ANSWER},
		'{'{ACT_GLOBAL_TO_LOCAL, 3 * ONE, -ONE, ONE, ONE, H_MIN}, 1'b0, NO_ANSWER},
		'{'{ACT_GLOBAL_TO_LOCAL, P_MAX, 32'sd0, 32'sd0, 32'sd0, 16'sd25736}, 1'b0, NO_ANSWER},
		'{'{ACT_GLOBAL_TO_LOCAL, 32'sd1, -32'sd1, 32'sd0, 32'sd0, -16'sd25736}, 1'b0, NO_ANSWER},
		// Clipping on the local to global side, and tiny values for rounding.
		'{'{ACT_LOCAL_TO_GLOBAL, P_MAX, P_MAX, P_MAX, P_MAX, 16'sd0}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, P_MIN, P_MAX, P_MIN, 32'sd0, 16'sd3217}, 1'b0, NO_ANSWER},
		'{'{ACT_LOCAL_TO_GLOBAL, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'sd1}, 1'b0, NO_ANSWER}
	};

	logic clk;
	logic arst_n;

	frt_pose_if pose_ch ();
	frt_result_if result_ch ();

	frame_rotate_translate_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose_ch),
		.result (result_ch)
	);

	// Points accepted by the block whose results have not arrived yet.
	xform_t expected_points [$];

	int failures = 0;
	int poses_sent = 0;
	int results_seen = 0;
	int clipped_seen = 0;
	int pose_stall_cycles = 0;
	bit all_offered = 1'b0;
	bit sender_calm = 1'b0;
	bit sink_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Reset is applied once and released on a clock edge.
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Round a Q.46 sum to Q16.16 (ties upward) and clip it to 32 bits.
	function automatic logic signed [31:0] round_clip(input longint acc, inout logic clipped);
		longint q;
		q = (acc + 64'sd536870912) >>> 30;
		if (q > Q_MAX) begin
			clipped = 1'b1;
			q = Q_MAX;
		end else if (q < Q_MIN) begin
			clipped = 1'b1;
			q = Q_MIN;
		end
		return q[31:0];
	endfunction

	// Expected output for one pose: CORDIC sine and cosine of the reduced
	// heading, then the rotation and translation with exact 64-bit products.
	function automatic xform_t transform_point(input pose_t p);
		longint ang;
		longint cx;
		longint cy;
		longint step_x;
		longint step_y;
		longint acc_x;
		longint acc_y;
		longint dx;
		longint dy;
		logic half_turn;
		logic clipped;
		int k;
		xform_t r;
		ang = longint'(p.heading) * 262144;
		half_turn = 1'b0;
		cx = GAIN_Q30;
		cy = 0;
		// One wrap into [-pi, pi] covers the whole Q3.12 range; beyond a
		// quarter turn the angle is folded and the signs are restored later.
		if (ang > ANGLE_PI)
			ang -= ANGLE_2PI;
		else if (ang < -ANGLE_PI)
			ang += ANGLE_2PI;
		if (ang > ANGLE_HALF_PI) begin
			ang -= ANGLE_PI;
			half_turn = 1'b1;
		end else if (ang < -ANGLE_HALF_PI) begin
			ang += ANGLE_PI;
			half_turn = 1'b1;
		end
		for (k = 0; k < CORDIC_N; k++) begin
			step_x = cy >>> k;
			step_y = cx >>> k;
			if (ang >= 0) begin
				cx -= step_x;
				cy += step_y;
				ang -= ARCTAN_Q30[5'(k)];
			end else begin
				cx += step_x;
				cy -= step_y;
				ang += ARCTAN_Q30[5'(k)];
			end
		end
		if (cx > UNIT_Q30) cx = UNIT_Q30;
		if (cx < -UNIT_Q30) cx = -UNIT_Q30;
		if (cy > UNIT_Q30) cy = UNIT_Q30;
		if (cy < -UNIT_Q30) cy = -UNIT_Q30;
		if (half_turn) begin
			cx = -cx;
			cy = -cy;
		end
		if (p.action == ACT_LOCAL_TO_GLOBAL) begin
			acc_x = longint'(p.px) * cx - longint'(p.py) * cy + longint'(p.rx) * UNIT_Q30;
			acc_y = longint'(p.px) * cy + longint'(p.py) * cx + longint'(p.ry) * UNIT_Q30;
		end else begin
			dx = longint'(p.px) - longint'(p.rx);
			dy = longint'(p.py) - longint'(p.ry);
			acc_x = dx * cx + dy * cy;
			acc_y = dy * cx - dx * cy;
		end
		clipped = 1'b0;
		r.x = round_clip(acc_x, clipped);
		r.y = round_clip(acc_y, clipped);
		r.sat = clipped;
		return r;
	endfunction

	// Idle length shared by both sides: mostly none, some short, a few long.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A coordinate drawn from a mix of magnitudes so that results both stay
	// in range and clip, and every bit of the field toggles.
	function automatic logic signed [31:0] random_coord();
		logic [31:0] raw;
		int roll;
		raw = $urandom;
		roll = $urandom_range(0, 9);
		if (roll < 4) return {{11{raw[20]}}, raw[20:0]};
		if (roll < 6) return {{5{raw[26]}}, raw[26:0]};
		if (roll < 9) return raw;
		case ($urandom_range(0, 4))
			0: return P_MAX;
			1: return P_MIN;
			2: return 32'sd1;
			3: return -32'sd1;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		p.action = $urandom_range(0, 1) ? ACT_GLOBAL_TO_LOCAL : ACT_LOCAL_TO_GLOBAL;
		p.px = random_coord();
		p.py = random_coord();
		p.rx = random_coord();
		p.ry = random_coord();
		p.heading = 16'($urandom);
		// Now and then sit right on a fold or wrap boundary, give or take one.
		if ($urandom_range(0, 7) == 0)
			p.heading = HEADING_EDGES[4'($urandom_range(0, 8))]
				+ 16'($urandom_range(0, 2)) - 16'sd1;
		return p;
	endfunction

	// Offer one pose, after an optional gap, and hold it until the block
	// takes it. The expectation is queued on the accepting edge.
	task automatic offer_pose(input pose_t p, input logic typed, input xform_t want);
		int gap;
		gap = sender_calm ? 0 : idle_len();
		if (gap > 0) begin
			pose_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose_ch.valid <= 1'b1;
		pose_ch.action <= p.action;
		pose_ch.point_x <= p.px;
		pose_ch.point_y <= p.py;
		pose_ch.robot_x <= p.rx;
		pose_ch.robot_y <= p.ry;
		pose_ch.heading <= p.heading;
		do @(posedge clk); while (pose_ch.ready !== 1'b1);
		expected_points.push_back(typed ? want : transform_point(p));
		poses_sent++;
		// Switch between gapped and back-to-back stretches now and then.
		if (poses_sent % 64 == 0) sender_calm = ($urandom_range(0, 2) == 0);
	endtask

	// Pose side: the directed table first, then the random poses.
	initial begin : pose_sender
		int k;
		pose_ch.valid <= 1'b0;
		pose_ch.action <= ACT_LOCAL_TO_GLOBAL;
		pose_ch.point_x <= '0;
		pose_ch.point_y <= '0;
		pose_ch.robot_x <= '0;
		pose_ch.robot_y <= '0;
		pose_ch.heading <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (k = 0; k < DIRECTED_ROWS; k++)
			offer_pose(DIRECTED[5'(k)].pose, DIRECTED[5'(k)].typed, DIRECTED[5'(k)].want);
		for (k = 0; k < RANDOM_POSES; k++)
			offer_pose(random_pose(), 1'b0, NO_ANSWER);
		pose_ch.valid <= 1'b0;
		all_offered = 1'b1;
	end

	// Result side: checks each transfer against the oldest expectation and
	// decides ready for the next cycle. After 300 and again after 1100
	// results it holds ready low long enough to fill the pipeline and force
	// the pose channel to stall.
	initial begin : result_sink
		int hold;
		int cycles;
		xform_t got;
		xform_t want;
		hold = 0;
		cycles = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pose_ch.valid === 1'b1 && pose_ch.ready !== 1'b1) pose_stall_cycles++;
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got = '{result_ch.out_x, result_ch.out_y, result_ch.saturated};
				if (expected_points.size() == 0) begin
					$display("%0t: result transfer with no point outstanding: x=%0d y=%0d sat=%0b",
						$time, got.x, got.y, got.sat);
					failures++;
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x) begin
						$display("%0t: out_x expected %0d, got %0d", $time, want.x, got.x);
						failures++;
					end
					if (got.y !== want.y) begin
						$display("%0t: out_y expected %0d, got %0d", $time, want.y, got.y);
						failures++;
					end
					if (got.sat !== want.sat) begin
						$display("%0t: saturated expected %0b, got %0b", $time, want.sat, got.sat);
						failures++;
					end
				end
				results_seen++;
				if (got.sat === 1'b1) clipped_seen++;
				if (results_seen == 300 || results_seen == 1100) hold = 200;
			end
			cycles++;
			if (cycles % 128 == 0) sink_calm = ($urandom_range(0, 2) == 0);
			if (hold == 0 && !sink_calm && $urandom_range(0, 3) == 0) hold = idle_len();
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Once every pose is in and every result is back, keep the clock running
	// to show up any stray transfer, then report.
	initial begin : run_end
		wait (all_offered);
		while (expected_points.size() != 0) @(posedge clk);
		repeat (CORDIC_N + 10) @(posedge clk);
		$display("Ran %0d poses (%0d from the directed table) and checked %0d results, %0d clipped.",
			poses_sent, DIRECTED_ROWS, results_seen, clipped_seen);
		$display("The pose channel was held off for %0d cycles by result-side back-pressure.",
			pose_stall_cycles);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin : watchdog
		#(8 * 1000000);
		$display("%0t: timeout with %0d results still outstanding", $time,
			expected_points.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/frt_pkg.sv
hdl/frt_pose_if.sv
hdl/frt_result_if.sv
hdl/frt_reduce.sv
hdl/frt_cordic.sv
hdl/frt_combine.sv
hdl/frame_rotate_translate_unit.sv
sim/tb.sv
